// ----- rtl/gqv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the glyph quad vertex generator.
// No dependencies; gqv_emit and the top level refer to this package by scoped names.
package gqv_pkg;

    localparam int GLYPH_COUNT = 95;
    localparam int SLOT_W      = $clog2(GLYPH_COUNT);
    localparam int CHAR_BASE   = 32;

    localparam int COORD_W = 16;
    localparam int TEX_W   = 16;
    localparam int CFG_W   = 8;

    localparam int VTX_COUNT = 6;
    localparam int VTX_IDX_W = 3;
    // Per-vertex selection, bit k for vertex k: right edge (x1, R), bottom edge (y1, v=1)
    localparam logic [VTX_COUNT-1:0] VTX_RIGHT_MASK  = 6'b110010;
    localparam logic [VTX_COUNT-1:0] VTX_BOTTOM_MASK = 6'b100110;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SETPOS = 2'd1,
        ACT_DRAW   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_GLYPH_HEIGHT  = 2'd0,
        CFG_SPACE_ADVANCE = 2'd1,
        CFG_LETTER_GAP    = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [TEX_W-1:0] left;
        logic [TEX_W-1:0] right;
        logic [7:0]       width;
    } t_glyph;

    localparam int GLYPH_W = $bits(t_glyph);

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [TEX_W-1:0]          left;
        logic [TEX_W-1:0]          right;
    } t_quad;

endpackage

// ----- rtl/gqv_cmd_if.sv -----
`timescale 1ns / 1ps
// Command channel: glyph loads, pen placement and characters to draw.
// Valid/ready handshake; no dependencies.
interface gqv_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [6:0]         glyph_slot;
    logic [15:0]        tex_left;
    logic [15:0]        tex_right;
    logic [7:0]         glyph_width;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         char_code;

    modport source (
        output valid, action, glyph_slot, tex_left, tex_right, glyph_width,
               start_x, start_y, char_code,
        input  ready
    );
    modport sink (
        input  valid, action, glyph_slot, tex_left, tex_right, glyph_width,
               start_x, start_y, char_code,
        output ready
    );
endinterface

// ----- rtl/gqv_vtx_if.sv -----
`timescale 1ns / 1ps
// Vertex channel: one textured vertex per transaction.
// Valid/ready handshake; no dependencies.
interface gqv_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        tex_u;
    logic               tex_v;
    logic               last;

    modport source (
        output valid, pos_x, pos_y, tex_u, tex_v, last,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, tex_u, tex_v, last,
        output ready
    );
endinterface

// ----- rtl/gqv_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gqv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/gqv_emit.sv -----
`timescale 1ns / 1ps
// Vertex sequencer: holds one glyph quad and walks its six vertices out.
// Depends on gqv_pkg and gqv_vtx_if.
module gqv_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  gqv_pkg::t_quad  i_quad,
    output logic            o_free,
    gqv_vtx_if.source       o_vtx
);
    localparam logic [gqv_pkg::VTX_IDX_W-1:0] LastIdx =
        gqv_pkg::VTX_IDX_W'(gqv_pkg::VTX_COUNT - 1);

    logic                            r_valid;
    logic [gqv_pkg::VTX_IDX_W-1:0]   r_idx;
    gqv_pkg::t_quad                  r_quad;
    logic                            is_last;
    logic                            use_right;
    logic                            use_bottom;

    assign is_last    = (r_idx == LastIdx);
    assign use_right  = gqv_pkg::VTX_RIGHT_MASK[r_idx];
    assign use_bottom = gqv_pkg::VTX_BOTTOM_MASK[r_idx];
    assign o_free     = !r_valid || (o_vtx.ready && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_quad  <= i_quad;
        end else if (r_valid && o_vtx.ready) begin
            // drop the quad after its final vertex
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_vtx.valid = r_valid;
    assign o_vtx.pos_x = use_right  ? r_quad.x1 : r_quad.x0;
    assign o_vtx.pos_y = use_bottom ? r_quad.y1 : r_quad.y0;
    assign o_vtx.tex_u = use_right  ? r_quad.right : r_quad.left;
    assign o_vtx.tex_v = use_bottom;
    assign o_vtx.last  = is_last;
endmodule

// ----- rtl/glyph_quad_vertex_generator_top.sv -----
`timescale 1ns / 1ps
// Bitmap text quad generator: glyph table RAM, pen registers, vertex sequencer.
// Depends on gqv_pkg, gqv_cmd_if, gqv_vtx_if, gqv_ram and gqv_emit.
// Path: a drawn glyph entry is read into stage 1, then its quad is loaded into
//   the vertex sequencer, which sends its six vertices on the single vertex port.
//   Commands stall while a draw waits in stage 1 for the busy sequencer.
// Reset: synchronous, active low; clears pen to (0,0) and registers to defaults.
//   The glyph table is not cleared and is undefined until loaded.
module glyph_quad_vertex_generator_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gqv_cmd_if.sink                  i_cmd,
    gqv_vtx_if.source                o_vtx,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [gqv_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int SlotW = gqv_pkg::SLOT_W;
    localparam int SumW  = gqv_pkg::COORD_W + 2;
    localparam logic signed [SumW-1:0] CoordMax = SumW'(32767);
    localparam logic signed [SumW-1:0] CoordMin = -SumW'(32768);

    typedef enum logic [1:0] {
        K_NONE,
        K_SETPOS,
        K_SPACE,
        K_DRAW
    } t_kind;

    // configuration
    logic [7:0] r_glyph_height;
    logic [7:0] r_space_advance;
    logic [7:0] r_letter_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_height  <= 8'd16;
            r_space_advance <= 8'd3;
            r_letter_gap    <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gqv_pkg::CFG_GLYPH_HEIGHT:  r_glyph_height  <= i_cfg_data;
                gqv_pkg::CFG_SPACE_ADVANCE: r_space_advance <= i_cfg_data;
                gqv_pkg::CFG_LETTER_GAP:    r_letter_gap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // command decode at acceptance
    logic             cmd_accept;
    logic             s1_adv;
    logic [8:0]       code_off;
    logic             slot_in_range;
    logic             load_in_range;
    t_kind            in_kind;
    logic             ram_we;
    logic [SlotW-1:0] ram_waddr;
    logic [SlotW-1:0] ram_raddr;
    gqv_pkg::t_glyph  ram_wdata;
    gqv_pkg::t_glyph  ram_rdata;
    logic             ram_re;

    assign code_off      = {1'b0, i_cmd.char_code} - 9'(gqv_pkg::CHAR_BASE);
    assign slot_in_range = (i_cmd.char_code >= 8'(gqv_pkg::CHAR_BASE))
                        && (code_off < 9'(gqv_pkg::GLYPH_COUNT));
    assign load_in_range = {2'b00, i_cmd.glyph_slot} < 9'(gqv_pkg::GLYPH_COUNT);

    always_comb begin
        in_kind = K_NONE;
        unique case (i_cmd.action)
            gqv_pkg::ACT_SETPOS: in_kind = K_SETPOS;
            gqv_pkg::ACT_DRAW: begin
                if (slot_in_range) begin
                    in_kind = (code_off == 9'd0) ? K_SPACE : K_DRAW;
                end
            end
            default: in_kind = K_NONE;
        endcase
    end

    assign cmd_accept = i_cmd.valid && i_cmd.ready;
    assign ram_we     = cmd_accept && (i_cmd.action == gqv_pkg::ACT_LOAD) && load_in_range;
    assign ram_waddr  = SlotW'(i_cmd.glyph_slot);
    assign ram_wdata  = '{left: i_cmd.tex_left, right: i_cmd.tex_right,
                          width: i_cmd.glyph_width};
    assign ram_re     = cmd_accept && (in_kind == K_DRAW);
    assign ram_raddr  = SlotW'(code_off);

    gqv_ram #(
        .WIDTH (gqv_pkg::GLYPH_W),
        .DEPTH (gqv_pkg::GLYPH_COUNT)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // stage 1: glyph entry arrives, pen is updated in command order
    logic                              r_s1_valid;
    t_kind                             r_s1_kind;
    logic signed [gqv_pkg::COORD_W-1:0] r_s1_x;
    logic signed [gqv_pkg::COORD_W-1:0] r_s1_y;
    logic signed [gqv_pkg::COORD_W-1:0] r_pen_x;
    logic signed [gqv_pkg::COORD_W-1:0] r_pen_y;
    logic signed [gqv_pkg::COORD_W-1:0] n_pen_x;
    logic signed [gqv_pkg::COORD_W-1:0] n_pen_y;

    logic signed [SumW-1:0] pen_x_ext;
    logic signed [SumW-1:0] pen_y_ext;
    logic signed [SumW-1:0] sum_right;
    logic signed [SumW-1:0] sum_adv;
    logic signed [SumW-1:0] sum_space;
    logic signed [SumW-1:0] diff_bottom;
    logic signed [gqv_pkg::COORD_W-1:0] sat_right;
    logic signed [gqv_pkg::COORD_W-1:0] sat_adv;
    logic signed [gqv_pkg::COORD_W-1:0] sat_space;
    logic signed [gqv_pkg::COORD_W-1:0] sat_bottom;

    gqv_pkg::t_quad quad;
    logic           emit_free;
    logic           emit_load;

    assign pen_x_ext   = SumW'(r_pen_x);
    assign pen_y_ext   = SumW'(r_pen_y);
    assign sum_right   = pen_x_ext + SumW'({1'b0, ram_rdata.width});
    assign sum_adv     = sum_right + SumW'({1'b0, r_letter_gap});
    assign sum_space   = pen_x_ext + SumW'({1'b0, r_space_advance});
    assign diff_bottom = pen_y_ext - SumW'({1'b0, r_glyph_height});

    // only upward overflow on x and downward on y are possible
    assign sat_right  = (sum_right > CoordMax) ? gqv_pkg::COORD_W'(CoordMax)
                                               : gqv_pkg::COORD_W'(sum_right);
    assign sat_adv    = (sum_adv > CoordMax)   ? gqv_pkg::COORD_W'(CoordMax)
                                               : gqv_pkg::COORD_W'(sum_adv);
    assign sat_space  = (sum_space > CoordMax) ? gqv_pkg::COORD_W'(CoordMax)
                                               : gqv_pkg::COORD_W'(sum_space);
    assign sat_bottom = (diff_bottom < CoordMin) ? gqv_pkg::COORD_W'(CoordMin)
                                                 : gqv_pkg::COORD_W'(diff_bottom);

    assign quad = '{x0: r_pen_x, y0: r_pen_y, x1: sat_right, y1: sat_bottom,
                    left: ram_rdata.left, right: ram_rdata.right};

    assign s1_adv      = !r_s1_valid || (r_s1_kind != K_DRAW) || emit_free;
    assign i_cmd.ready = s1_adv;
    assign emit_load   = r_s1_valid && (r_s1_kind == K_DRAW) && emit_free;

    always_comb begin
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        if (r_s1_valid && s1_adv) begin
            unique case (r_s1_kind)
                K_SETPOS: begin
                    n_pen_x = r_s1_x;
                    n_pen_y = r_s1_y;
                end
                K_SPACE: n_pen_x = sat_space;
                K_DRAW:  n_pen_x = sat_adv;
                K_NONE:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_kind  <= K_NONE;
            r_pen_x    <= '0;
            r_pen_y    <= '0;
        end else begin
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
            if (s1_adv) begin
                r_s1_valid <= i_cmd.valid;
                r_s1_kind  <= in_kind;
                r_s1_x     <= i_cmd.start_x;
                r_s1_y     <= i_cmd.start_y;
            end
        end
    end

    gqv_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit_load),
        .i_quad  (quad),
        .o_free  (emit_free),
        .o_vtx   (o_vtx)
    );
endmodule

// ----- rtl/gqv_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the glyph quad vertex generator, bound to the top level.
// Depends on glyph_quad_vertex_generator_top.
module gqv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_vtx_valid,
    input logic        i_vtx_ready,
    input logic [15:0] i_pos_x,
    input logic [15:0] i_pos_y,
    input logic [15:0] i_tex_u,
    input logic        i_tex_v,
    input logic        i_last
);
    // a stalled vertex transaction keeps its payload
    a_vtx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx_valid && !i_vtx_ready |=> i_vtx_valid && $stable(i_pos_x)
            && $stable(i_pos_y) && $stable(i_tex_u) && $stable(i_tex_v)
            && $stable(i_last))
        else $error("vertex payload changed while stalled");

    // reset empties the vertex output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_vtx_valid)
        else $error("vertex valid after reset");

    // command back-pressure only comes from a busy vertex sequencer
    a_cmd_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_ready |-> i_vtx_valid)
        else $error("command stalled with no vertex pending");

    // the closing vertex of a quad sits on the bottom edge
    a_last_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx_valid && i_last |-> i_tex_v)
        else $error("last vertex not on bottom edge");

    // a completed quad is followed by a first vertex on the top edge
    a_next_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx_valid && i_vtx_ready && i_last ##1 i_vtx_valid |-> !i_tex_v && !i_last)
        else $error("quad did not restart at top edge");
endmodule

bind glyph_quad_vertex_generator_top gqv_checker u_gqv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_vtx_valid (o_vtx.valid),
    .i_vtx_ready (o_vtx.ready),
    .i_pos_x     (o_vtx.pos_x),
    .i_pos_y     (o_vtx.pos_y),
    .i_tex_u     (o_vtx.tex_u),
    .i_tex_v     (o_vtx.tex_v),
    .i_last      (o_vtx.last)
);
